// File: hw/rtl/cns_pkg.sv
`timescale 1ns / 1ps
package cns_pkg;
  localparam int unsigned DistW = 32;
  localparam int unsigned IdxW = 16;
  localparam int unsigned NumCfg = 4;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StEmit = 3'b010,
    StDone = 3'b100
  } state_e;

  typedef struct packed {
    logic insert;
    logic emit_start;
    logic emit_step;
    logic clear;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic emit_last;
  } stat_t;
endpackage

// File: hw/rtl/cns_ctrl.sv
`timescale 1ns / 1ps
module cns_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           op_i,
  input  logic           keep_i,
  input  cns_pkg::stat_t stat_i,
  output cns_pkg::ctrl_t ctrl_o,
  output logic           busy_o,
  output logic           valid_o
);
  import cns_pkg::*;

  state_e state_q, state_d;
  logic   acc;

  assign acc = start_i && (state_q == StIdle);
  assign busy_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    ctrl_o = '0;
    valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (acc && !op_i) begin
          ctrl_o.insert = keep_i;
        end else if (acc && op_i) begin
          ctrl_o.emit_start = 1'b1;
          state_d = StEmit;
        end
      end
      StEmit: begin
        valid_o = 1'b1;
        ctrl_o.emit_step = 1'b1;
        if (stat_i.empty || stat_i.emit_last) begin
          ctrl_o.clear = 1'b1;
          state_d = StIdle;
        end
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// File: hw/rtl/cns_dpath.sv
`timescale 1ns / 1ps
module cns_dpath #(
  parameter int unsigned MaxN = 32,
  parameter int unsigned NumTypes = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cns_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cns_pkg::DistW-1:0] cfg_data_i,
  input  logic [15:0]               center_index_i,
  input  logic                      center_type_i,
  input  logic [15:0]               neighbor_index_i,
  input  logic                      neighbor_type_i,
  input  logic [cns_pkg::DistW-1:0] dist_sq_i,
  input  cns_pkg::ctrl_t            ctrl_i,
  output cns_pkg::stat_t            stat_o,
  output logic                      keep_o,
  output logic [15:0]               center_index_res_o,
  output logic [15:0]               neighbor_out_o,
  output logic [4:0]                rank_o,
  output logic [5:0]                neighbor_count_o,
  output logic                      has_neighbor_o,
  output logic                      overflow_o
);
  import cns_pkg::*;
  localparam int unsigned CntW = $clog2(MaxN + 1);

  logic [DistW-1:0] cut_q [NumCfg];
  logic [IdxW-1:0]  idx_q [MaxN];
  logic [DistW-1:0] dist_q [MaxN];
  logic [CntW-1:0]  cnt_q;
  logic             ovf_q;
  logic [CntW-1:0]  ptr_q;
  logic [15:0]      ctr_q;
  logic             ct, nt;
  logic [MaxN-1:0]  gt;
  logic             full;

  assign ct = (NumTypes > 1) ? center_type_i : 1'b0;
  assign nt = (NumTypes > 1) ? neighbor_type_i : 1'b0;
  assign keep_o = (neighbor_index_i != center_index_i) &&
                  (dist_sq_i < cut_q[{ct, nt}]);
  assign full = (cnt_q == CntW'(MaxN));

  always_comb begin
    for (int i = 0; i < MaxN; i++) begin
      gt[i] = (CntW'(i) < cnt_q) && (dist_q[i] > dist_sq_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert) begin
      for (int i = 0; i < MaxN; i++) begin
        if (gt[i] || (CntW'(i) == cnt_q)) begin
          if (i > 0 && gt[i - ((i > 0) ? 1 : 0)] && i != 0) begin
            idx_q[i]  <= idx_q[i-1];
            dist_q[i] <= dist_q[i-1];
          end else begin
            idx_q[i]  <= neighbor_index_i;
            dist_q[i] <= dist_sq_i;
          end
        end
      end
    end
    if (ctrl_i.emit_start) ctr_q <= center_index_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCfg; i++) begin
        cut_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) cut_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      ptr_q <= '0;
    end else begin
      if (ctrl_i.insert) begin
        if (full) ovf_q <= 1'b1;
        else cnt_q <= cnt_q + 1'b1;
      end
      if (ctrl_i.emit_start) ptr_q <= '0;
      else if (ctrl_i.emit_step) ptr_q <= ptr_q + 1'b1;
      if (ctrl_i.clear) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end
    end
  end

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.emit_last = (ptr_q + 1'b1 == cnt_q);
  assign center_index_res_o = ctr_q;
  assign neighbor_out_o = stat_o.empty ? '0 : idx_q[ptr_q[$clog2(MaxN)-1:0]];
  assign rank_o = stat_o.empty ? '0 : 5'(ptr_q);
  assign neighbor_count_o = 6'(cnt_q);
  assign has_neighbor_o = !stat_o.empty;
  assign overflow_o = ovf_q;
endmodule

// File: hw/rtl/cutoff_neighbor_sort.sv
`timescale 1ns / 1ps
// Cutoff neighbor list, sorted by squared distance.
// Command channel: start_i with op_i and payload, accepted when busy_o is low.
// A candidate (op 0) is filtered against the type-pair cutoff and inserted
// in sorted order in the cycle it is accepted; one candidate per cycle.
// An end item (op 1) emits the list: results appear one per cycle, starting
// the cycle after acceptance, each marked by result_valid_o; last_o flags
// the final beat. An empty list gives one beat with has_neighbor_o low.
// busy_o stays high while the beats of an end item are emitted.
// Config: cfg_we_i writes cfg_data_i to cutoff register cfg_idx_i.
// Reset clears the list count, the overflow flag, the controller and the
// cutoff registers. The receiver cannot stall: every beat is
// presented for exactly one cycle.
module cutoff_neighbor_sort #(
  parameter int unsigned MAX_NEIGHBORS = 32,
  parameter int unsigned NUM_TYPES = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        op_i,
  input  logic [15:0] center_index_i,
  input  logic        center_type_i,
  input  logic [15:0] neighbor_index_i,
  input  logic        neighbor_type_i,
  input  logic [31:0] dist_sq_i,
  output logic        result_valid_o,
  output logic [15:0] center_index_res_o,
  output logic [15:0] neighbor_out_o,
  output logic [4:0]  rank_o,
  output logic [5:0]  neighbor_count_o,
  output logic        has_neighbor_o,
  output logic        overflow_o,
  output logic        last_o
);
  import cns_pkg::*;
  ctrl_t ctrl;
  stat_t stat;
  logic  keep;

  cns_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .op_i, .keep_i(keep), .stat_i(stat),
    .ctrl_o(ctrl), .busy_o, .valid_o(result_valid_o)
  );

  cns_dpath #(.MaxN(MAX_NEIGHBORS), .NumTypes(NUM_TYPES)) u_dpath (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .center_index_i,
    .center_type_i, .neighbor_index_i, .neighbor_type_i, .dist_sq_i,
    .ctrl_i(ctrl), .stat_o(stat), .keep_o(keep), .center_index_res_o,
    .neighbor_out_o, .rank_o, .neighbor_count_o, .has_neighbor_o, .overflow_o
  );

  assign last_o = stat.empty || stat.emit_last;
endmodule
